// File: rtl/core/wsfd_pkg.sv
`timescale 1ns / 1ps

package wsfd_pkg;

  // parse phases, one-hot
  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_MASK    = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  localparam int unsigned LEN_W = 63;

  localparam logic [3:0] OP_CONTINUATION = 4'h0;
  localparam logic [6:0] LEN7_EXT16      = 7'd126;
  localparam logic [6:0] LEN7_EXT64      = 7'd127;
  localparam logic [2:0] EXT16_BYTES     = 3'd2;
  // eight bytes wrap the 3-bit counter to zero
  localparam logic [2:0] EXT64_BYTES     = 3'd0;
  localparam logic [2:0] KEY_BYTES       = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic [3:0] message_opcode;
    logic       frame_end;
    logic       message_end;
  } result_t;

endpackage

// File: rtl/core/wsfd_parser.sv
`timescale 1ns / 1ps

module wsfd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_acc,
  input  logic [7:0]        stream_byte,
  output logic              res_valid,
  output wsfd_pkg::result_t res
);

  wsfd_pkg::phase_t                 phase_r, phase_nxt;
  logic [2:0]                       cnt_r, cnt_nxt;
  logic                             long_r, long_nxt;
  logic                             fin_r, fin_nxt;
  logic [3:0]                       op_r, op_nxt;
  logic                             masked_r, masked_nxt;
  logic [wsfd_pkg::LEN_W-1:0]       rem_r, rem_nxt;
  logic [31:0]                      key_r, key_nxt;
  logic [1:0]                       pos_r, pos_nxt;
  logic                             infrag_r, infrag_nxt;
  logic [3:0]                       fragop_r, fragop_nxt;

  logic [3:0]                       rep_op;
  logic [6:0]                       len7;
  logic [2:0]                       cnt_inc;
  logic [wsfd_pkg::LEN_W-1:0]       rem_dec;
  logic [wsfd_pkg::LEN_W-1:0]       rem_hdr;
  logic [wsfd_pkg::LEN_W-1:0]       rem_ext;
  logic [7:0]                       key_byte;
  logic                             hdr_done;
  logic                             close;

  assign rep_op   = (op_r == wsfd_pkg::OP_CONTINUATION && infrag_r) ? fragop_r : op_r;
  assign len7     = stream_byte[6:0];
  assign cnt_inc  = cnt_r + 3'd1;
  assign rem_dec  = rem_r - {{(wsfd_pkg::LEN_W-1){1'b0}}, 1'b1};
  assign rem_hdr  = {{(wsfd_pkg::LEN_W-7){1'b0}}, len7};
  assign rem_ext  = {rem_r[wsfd_pkg::LEN_W-9:0], stream_byte};

  always_comb begin
    case (pos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    long_nxt   = long_r;
    fin_nxt    = fin_r;
    op_nxt     = op_r;
    masked_nxt = masked_r;
    rem_nxt    = rem_r;
    key_nxt    = key_r;
    pos_nxt    = pos_r;
    infrag_nxt = infrag_r;
    fragop_nxt = fragop_r;
    hdr_done   = 1'b0;
    close      = 1'b0;
    res_valid  = 1'b0;
    res        = '0;

    case (phase_r)
      wsfd_pkg::PH_HDR0: begin
        fin_nxt   = stream_byte[7];
        op_nxt    = stream_byte[3:0];
        phase_nxt = wsfd_pkg::PH_HDR1;
      end
      wsfd_pkg::PH_HDR1: begin
        masked_nxt = stream_byte[7];
        cnt_nxt    = 3'd0;
        if (len7 < wsfd_pkg::LEN7_EXT16) begin
          rem_nxt = rem_hdr;
          key_nxt = '0;
          if (stream_byte[7]) begin
            phase_nxt = wsfd_pkg::PH_MASK;
          end else begin
            hdr_done = 1'b1;
          end
        end else begin
          rem_nxt   = '0;
          long_nxt  = (len7 == wsfd_pkg::LEN7_EXT64);
          phase_nxt = wsfd_pkg::PH_EXTLEN;
        end
      end
      wsfd_pkg::PH_EXTLEN: begin
        rem_nxt = rem_ext;
        cnt_nxt = cnt_inc;
        if (cnt_inc == (long_r ? wsfd_pkg::EXT64_BYTES : wsfd_pkg::EXT16_BYTES)) begin
          cnt_nxt = 3'd0;
          key_nxt = '0;
          if (masked_r) begin
            phase_nxt = wsfd_pkg::PH_MASK;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      wsfd_pkg::PH_MASK: begin
        key_nxt = {key_r[23:0], stream_byte};
        cnt_nxt = cnt_inc;
        if (cnt_inc == wsfd_pkg::KEY_BYTES) begin
          cnt_nxt  = 3'd0;
          hdr_done = 1'b1;
        end
      end
      wsfd_pkg::PH_PAYLOAD: begin
        pos_nxt                = pos_r + 2'd1;
        rem_nxt                = rem_dec;
        res_valid              = 1'b1;
        res.data_byte          = stream_byte ^ (masked_r ? key_byte : 8'h00);
        res.has_data           = 1'b1;
        res.message_opcode     = rep_op;
        res.frame_end          = (rem_dec == '0);
        res.message_end        = (rem_dec == '0) && fin_r;
        close                  = (rem_dec == '0);
      end
      default: begin
        phase_nxt = wsfd_pkg::PH_HDR0;
      end
    endcase

    // header complete: empty marker for a zero-length frame, else payload
    if (hdr_done) begin
      if (rem_nxt == '0) begin
        res_valid          = 1'b1;
        res.data_byte      = 8'h00;
        res.has_data       = 1'b0;
        res.message_opcode = rep_op;
        res.frame_end      = 1'b1;
        res.message_end    = fin_r;
        close              = 1'b1;
      end else begin
        pos_nxt   = 2'd0;
        phase_nxt = wsfd_pkg::PH_PAYLOAD;
      end
    end

    // fragment tracking at end of frame
    if (close) begin
      if (fin_r) begin
        if (op_r == wsfd_pkg::OP_CONTINUATION) begin
          infrag_nxt = 1'b0;
        end
      end else if (!infrag_r) begin
        fragop_nxt = op_r;
        infrag_nxt = 1'b1;
      end
      phase_nxt = wsfd_pkg::PH_HDR0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= wsfd_pkg::PH_HDR0;
      cnt_r    <= '0;
      long_r   <= 1'b0;
      fin_r    <= 1'b0;
      op_r     <= '0;
      masked_r <= 1'b0;
      rem_r    <= '0;
      key_r    <= '0;
      pos_r    <= '0;
      infrag_r <= 1'b0;
      fragop_r <= '0;
    end else if (byte_acc) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      long_r   <= long_nxt;
      fin_r    <= fin_nxt;
      op_r     <= op_nxt;
      masked_r <= masked_nxt;
      rem_r    <= rem_nxt;
      key_r    <= key_nxt;
      pos_r    <= pos_nxt;
      infrag_r <= infrag_nxt;
      fragop_r <= fragop_nxt;
    end
  end

endmodule

// File: rtl/core/websocket_frame_deframer.sv
`timescale 1ns / 1ps

// WebSocket (RFC 6455 receive side) frame deframer. Takes the raw stream one
// byte per transaction, parses the two header bytes, the optional 16-bit or
// 64-bit big-endian length (top bit ignored) and the optional 4-byte masking
// key, then gives one result transaction per payload byte, unmasked, with the
// message opcode (continuation frames of an open fragmented message report the
// first fragment's opcode), a frame_end flag and a message_end flag. A frame
// with zero payload gives one result with has_data low. Header, length and key
// bytes give no result. Throughput is one byte per clock while in_stall is low:
// each byte is parsed in the cycle it is accepted, and its result is registered
// into the output register, or into the skid entry while out_stall holds it. A
// two-entry output buffer (output register plus skid) lets one more result
// transaction in while out_stall is high; in_stall rises only once the skid
// entry is occupied, and bytes that give no result keep flowing until then.

module websocket_frame_deframer (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_stream_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic       out_has_data,
  output logic [3:0] out_message_opcode,
  output logic       out_frame_end,
  output logic       out_message_end
);

  logic              byte_acc;
  logic              res_valid;
  wsfd_pkg::result_t res;

  // output register and skid entry
  logic              main_valid_r, main_valid_nxt;
  wsfd_pkg::result_t main_r, main_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  wsfd_pkg::result_t skid_r, skid_nxt;

  // skid full means one result is already parked behind the output register
  assign in_stall = skid_valid_r;
  assign byte_acc = in_valid && !in_stall;

  wsfd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_acc    (byte_acc),
    .stream_byte (in_stream_byte),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_comb begin
    main_valid_nxt = main_valid_r;
    main_nxt       = main_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (!main_valid_r || !out_stall) begin
      // output register free or being taken this cycle
      if (skid_valid_r) begin
        main_valid_nxt = 1'b1;
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = byte_acc && res_valid;
        main_nxt       = res;
      end
    end else if (byte_acc && res_valid) begin
      // output held: park the new result
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid          = main_valid_r;
  assign out_data_byte      = main_r.data_byte;
  assign out_has_data       = main_r.has_data;
  assign out_message_opcode = main_r.message_opcode;
  assign out_frame_end      = main_r.frame_end;
  assign out_message_end    = main_r.message_end;

endmodule

// File: bench/websocket_frame_deframer_tb.sv
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;

  // opcodes used by the stimulus
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam int RANDOM_BYTES = 600;
  // receiver hold-off long enough to fill the output register and skid entry
  localparam int LONG_HOLD    = 200;
  localparam int HOLD_AT      = 120;
  // cycles with no transaction on either side before the run is abandoned
  localparam int IDLE_LIMIT   = 2000;
  // two-entry output buffer, the tail wait lets it drain
  localparam int TAIL_CYCLES  = 16;
  localparam int BIG_LEN      = 32770;

  typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_kind_t;

  typedef struct {
    logic [7:0] data;
    int         gap;
  } stream_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_stream_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_data_byte;
  logic       out_has_data;
  logic [3:0] out_message_opcode;
  logic       out_frame_end;
  logic       out_message_end;

  websocket_frame_deframer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_stream_byte     (in_stream_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_data_byte      (out_data_byte),
    .out_has_data       (out_has_data),
    .out_message_opcode (out_message_opcode),
    .out_frame_end      (out_frame_end),
    .out_message_end    (out_message_end)
  );

  always #4 clk = ~clk;

  // raw stream waiting to be offered, each byte with its lead-in gap
  stream_byte_t      stream_q[$];
  // results the deframer owes us, oldest first
  wsfd_pkg::result_t payload_q[$];

  int error_count = 0;
  int byte_total  = 0;
  int tx_wait     = 0;
  int rx_wait     = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  bit hold_done   = 1'b0;
  bit rx_quiet    = 1'b0;
  bit frame_quiet = 1'b0;

  // ---------------------------------------------------------------------------
  // deframer state as we expect it to be
  // ---------------------------------------------------------------------------
  wsfd_pkg::phase_t hdr_phase = wsfd_pkg::PH_HDR0;
  int          field_cnt = 0;
  logic        long_len = 1'b0;
  logic        cur_fin = 1'b0;
  logic [3:0]  cur_op = 4'h0;
  logic        cur_masked = 1'b0;
  logic [62:0] bytes_left = '0;
  logic [31:0] unmask_key = '0;
  logic [1:0]  key_index = 2'd0;
  logic        frag_open = 1'b0;
  logic [3:0]  frag_op = 4'h0;

  // continuation frames inside an open message report the opening opcode
  function automatic logic [3:0] message_op();
    return (cur_op == wsfd_pkg::OP_CONTINUATION && frag_open) ? frag_op : cur_op;
  endfunction

  task automatic close_frame();
    if (cur_fin) begin
      if (cur_op == wsfd_pkg::OP_CONTINUATION) frag_open = 1'b0;
    end else if (!frag_open) begin
      frag_op = cur_op;
      frag_open = 1'b1;
    end
    hdr_phase = wsfd_pkg::PH_HDR0;
  endtask

  // header fully parsed: empty marker for a zero-length frame, else payload
  task automatic header_complete();
    wsfd_pkg::result_t r;
    if (bytes_left == '0) begin
      r = '{data_byte: 8'h00, has_data: 1'b0, message_opcode: message_op(),
            frame_end: 1'b1, message_end: cur_fin};
      payload_q.insert(payload_q.size(), r);
      close_frame();
    end else begin
      key_index = 2'd0;
      hdr_phase = wsfd_pkg::PH_PAYLOAD;
    end
  endtask

  task automatic length_complete();
    unmask_key = '0;
    if (cur_masked) begin
      field_cnt = 0;
      hdr_phase = wsfd_pkg::PH_MASK;
    end else begin
      header_complete();
    end
  endtask

  // advance the expected state by one accepted stream byte
  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0]        key_byte;
    logic [3:0]        op;
    logic              last;
    wsfd_pkg::result_t r;
    case (hdr_phase)
      wsfd_pkg::PH_HDR0: begin
        // reserved bits 6..4 are simply dropped
        cur_fin = b[7];
        cur_op = b[3:0];
        hdr_phase = wsfd_pkg::PH_HDR1;
      end
      wsfd_pkg::PH_HDR1: begin
        cur_masked = b[7];
        bytes_left = '0;
        field_cnt = 0;
        if (b[6:0] < wsfd_pkg::LEN7_EXT16) begin
          bytes_left = 63'(b[6:0]);
          length_complete();
        end else begin
          long_len = (b[6:0] == wsfd_pkg::LEN7_EXT64);
          hdr_phase = wsfd_pkg::PH_EXTLEN;
        end
      end
      wsfd_pkg::PH_EXTLEN: begin
        // big-endian, the top bit of a 64-bit length falls off the end
        bytes_left = {bytes_left[54:0], b};
        field_cnt++;
        if (field_cnt == (long_len ? 8 : 2)) begin
          field_cnt = 0;
          length_complete();
        end
      end
      wsfd_pkg::PH_MASK: begin
        unmask_key = {unmask_key[23:0], b};
        field_cnt++;
        if (field_cnt == 4) begin
          field_cnt = 0;
          header_complete();
        end
      end
      wsfd_pkg::PH_PAYLOAD: begin
        op = message_op();
        key_byte = cur_masked ? 8'(unmask_key >> (24 - 8 * key_index)) : 8'h00;
        key_index = key_index + 2'd1;
        bytes_left = bytes_left - 63'd1;
        last = (bytes_left == '0);
        r = '{data_byte: b ^ key_byte, has_data: 1'b1, message_opcode: op,
              frame_end: last, message_end: last & cur_fin};
        payload_q.insert(payload_q.size(), r);
        if (last) close_frame();
      end
      default: hdr_phase = wsfd_pkg::PH_HDR0;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b);
    stream_byte_t e;
    e = '{data: b, gap: frame_quiet ? 0 : int'($urandom_range(0, 4))};
    stream_q.insert(stream_q.size(), e);
    byte_total++;
  endtask

  // one frame: header, optional extended length, optional key, n_data payload bytes
  task automatic send_frame(input logic [7:0] first, input logic masked,
                            input len_kind_t kind, input logic [63:0] len, input int n_data);
    logic [31:0] key;
    key = $urandom;
    push_byte(first);
    case (kind)
      LEN_SHORT: push_byte({masked, len[6:0]});
      LEN_EXT16: begin
        push_byte({masked, wsfd_pkg::LEN7_EXT16});
        push_byte(len[15:8]);
        push_byte(len[7:0]);
      end
      default: begin
        push_byte({masked, wsfd_pkg::LEN7_EXT64});
        for (int i = 7; i >= 0; i--) push_byte(len[8 * i +: 8]);
      end
    endcase
    if (masked) for (int i = 3; i >= 0; i--) push_byte(key[8 * i +: 8]);
    for (int i = 0; i < n_data; i++) push_byte(8'($urandom));
  endtask

  // fragment-heavy traffic, continuation the most frequent opcode, so that continuation handling gets exercised
  function automatic logic [3:0] pick_opcode();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return wsfd_pkg::OP_CONTINUATION;
      4, 5:       return OP_TEXT;
      6:          return OP_BINARY;
      7:          return OP_PING;
      8:          return $urandom_range(0, 1) ? OP_PONG : OP_CLOSE;
      default:    return 4'($urandom);
    endcase
  endfunction

  task automatic random_frame();
    logic [63:0] len;
    logic        masked;
    logic [7:0]  first;
    int          sel;
    masked = 1'($urandom);
    first = {1'($urandom_range(0, 2) != 0), 3'b000, pick_opcode()};
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      len = 64'($urandom_range(0, 12));
      send_frame(first, masked, LEN_SHORT, len, int'(len));
    end else if (sel < 9) begin
      len = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 3))
                                         : 64'($urandom_range(126, 300));
      send_frame(first, masked, LEN_EXT16, len, int'(len));
    end else begin
      len = 64'($urandom_range(0, 20));
      len[63] = 1'($urandom);
      send_frame(first, masked, LEN_EXT64, len, int'(len[62:0]));
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued bytes, each after its own gap
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait <= 0;
    end else begin
      if (in_valid && !in_stall) deframe_byte(in_stream_byte);
      // only touch the payload when the current transaction is gone
      if (!in_valid || !in_stall) begin
        if (stream_q.size() != 0 && tx_wait >= stream_q[0].gap) begin
          in_valid <= 1'b1;
          in_stream_byte <= stream_q[0].data;
          void'(stream_q.pop_front());
          tx_wait <= 0;
        end else begin
          in_valid <= 1'b0;
          if (stream_q.size() != 0) tx_wait <= tx_wait + 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result transaction and paces out_stall
  // ---------------------------------------------------------------------------
  task automatic check_result();
    wsfd_pkg::result_t want;
    if (payload_q.size() == 0) begin
      $error("unexpected result: data_byte %0h has_data %0b opcode %0h",
             out_data_byte, out_has_data, out_message_opcode);
      error_count++;
    end else begin
      want = payload_q.pop_front();
      if (out_data_byte !== want.data_byte) begin
        $error("data_byte: expected %0h, actual %0h", want.data_byte, out_data_byte);
        error_count++;
      end
      if (out_has_data !== want.has_data) begin
        $error("has_data: expected %0b, actual %0b", want.has_data, out_has_data);
        error_count++;
      end
      if (out_message_opcode !== want.message_opcode) begin
        $error("message_opcode: expected %0h, actual %0h",
               want.message_opcode, out_message_opcode);
        error_count++;
      end
      if (out_frame_end !== want.frame_end) begin
        $error("frame_end: expected %0b, actual %0b", want.frame_end, out_frame_end);
        error_count++;
      end
      if (out_message_end !== want.message_end) begin
        $error("message_end: expected %0b, actual %0b", want.message_end, out_message_end);
        error_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result();
        results_seen++;
        // occasionally swap between stalling at random and taking everything
        if ($urandom_range(0, 63) == 0) rx_quiet = ~rx_quiet;
        rx_wait = rx_quiet ? 0 : int'($urandom_range(0, 4));
        // one long hold-off while the sender keeps going, to back up the input
        if (!hold_done && results_seen == HOLD_AT) begin
          rx_wait = LONG_HOLD;
          hold_done = 1'b1;
        end
      end else if (rx_wait > 0) begin
        rx_wait = rx_wait - 1;
      end
      out_stall <= (rx_wait > 0);
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: no transaction on either channel for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stream contents and end of run
  // ---------------------------------------------------------------------------
  initial begin
    // directed frames
    frame_quiet = 1'b0;
    send_frame({1'b1, 3'b000, OP_TEXT}, 1'b0, LEN_SHORT, 64'd3, 3);
    send_frame({1'b1, 3'b000, OP_BINARY}, 1'b1, LEN_SHORT, 64'd5, 5);
    // empty frames, plain and masked
    send_frame({1'b1, 3'b000, OP_PING}, 1'b0, LEN_SHORT, 64'd0, 0);
    send_frame({1'b1, 3'b000, OP_PONG}, 1'b1, LEN_SHORT, 64'd0, 0);
    // fragmented message with a control frame in the middle, closed by an empty frame
    send_frame({1'b0, 3'b000, OP_TEXT}, 1'b0, LEN_SHORT, 64'd2, 2);
    send_frame({1'b1, 3'b000, OP_PING}, 1'b0, LEN_SHORT, 64'd1, 1);
    send_frame({1'b0, 3'b000, wsfd_pkg::OP_CONTINUATION}, 1'b1, LEN_SHORT, 64'd1, 1);
    send_frame({1'b1, 3'b000, wsfd_pkg::OP_CONTINUATION}, 1'b0, LEN_SHORT, 64'd0, 0);
    // continuation with nothing open
    send_frame({1'b1, 3'b000, wsfd_pkg::OP_CONTINUATION}, 1'b0, LEN_SHORT, 64'd1, 1);
    // reserved bits set, reserved opcode
    send_frame({1'b1, 3'b111, 4'hB}, 1'b0, LEN_SHORT, 64'd1, 1);
    // extended lengths of zero, and the unused top bit of the 64-bit length
    send_frame({1'b1, 3'b000, OP_BINARY}, 1'b0, LEN_EXT16, 64'd0, 0);
    send_frame({1'b1, 3'b000, OP_BINARY}, 1'b0, LEN_EXT64, {1'b1, 63'd0}, 0);
    send_frame({1'b1, 3'b000, OP_TEXT}, 1'b1, LEN_EXT64, {1'b1, 63'd3}, 3);
    // largest short length
    send_frame({1'b1, 3'b000, OP_BINARY}, 1'b0, LEN_SHORT, 64'd125, 125);

    // random frames, with a little noise
    byte_total = 0;
    while (byte_total < RANDOM_BYTES) begin
      frame_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 6) == 0) begin
        send_frame(8'($urandom), 1'b0, LEN_SHORT, 64'd0, 0);
        // noise: any first byte, then a short frame of arbitrary size
        stream_q.delete(stream_q.size() - 1);
        byte_total--;
        begin
          logic [6:0] n;
          n = 7'($urandom_range(0, 125));
          push_byte({1'($urandom), n});
          if (stream_q[$].data[7]) for (int i = 0; i < 4; i++) push_byte(8'($urandom));
          for (int i = 0; i < int'(n); i++) push_byte(8'($urandom));
        end
      end else begin
        random_frame();
      end
    end

    // stream ends inside a frame whose 16-bit length needs bit 15
    frame_quiet = 1'b0;
    send_frame({1'b1, 3'b000, OP_BINARY}, 1'b1, LEN_EXT16, 64'(BIG_LEN), 6);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // all bytes taken, then all results in
    do @(negedge clk); while (stream_q.size() != 0 || in_valid);
    do @(negedge clk); while (payload_q.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (payload_q.size() != 0) begin
      $error("%0d results never arrived", payload_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
